// File: hdl/jst_pkg.sv
package jst_pkg;

	localparam int NEST_MAX = 32;
	localparam int DEPTH_W  = $clog2(NEST_MAX + 1);
	localparam int ADDR_W   = (NEST_MAX > 1) ? $clog2(NEST_MAX) : 1;

	localparam logic [3:0] EV_CHAR      = 4'd0;
	localparam logic [3:0] EV_ARR_START = 4'd1;
	localparam logic [3:0] EV_ARR_END   = 4'd2;
	localparam logic [3:0] EV_DIC_START = 4'd3;
	localparam logic [3:0] EV_DIC_END   = 4'd4;
	localparam logic [3:0] EV_STRING    = 4'd5;
	localparam logic [3:0] EV_KEY       = 4'd6;
	localparam logic [3:0] EV_CHARACTER = 4'd7;
	localparam logic [3:0] EV_NUMBER    = 4'd8;
	localparam logic [3:0] EV_NULL      = 4'd9;
	localparam logic [3:0] EV_TRUE      = 4'd10;
	localparam logic [3:0] EV_FALSE     = 4'd11;
	localparam logic [3:0] EV_ERROR     = 4'd12;

	localparam logic [3:0] ERR_NONE         = 4'd0;
	localparam logic [3:0] ERR_NOT_START    = 4'd1;
	localparam logic [3:0] ERR_COMMA_EXTRA  = 4'd2;
	localparam logic [3:0] ERR_COMMA_NEEDED = 4'd3;
	localparam logic [3:0] ERR_COLON_EXTRA  = 4'd4;
	localparam logic [3:0] ERR_COLON_NEEDED = 4'd5;
	localparam logic [3:0] ERR_BAD_CHAR     = 4'd6;
	localparam logic [3:0] ERR_KEY          = 4'd7;
	localparam logic [3:0] ERR_NUMBER       = 4'd8;
	localparam logic [3:0] ERR_WORD         = 4'd9;
	localparam logic [3:0] ERR_CHAR_EMPTY   = 4'd10;
	localparam logic [3:0] ERR_CHAR_MANY    = 4'd11;
	localparam logic [3:0] ERR_END          = 4'd12;
	localparam logic [3:0] ERR_DEPTH        = 4'd13;

	localparam logic [2:0] LEAF_NONE   = 3'd0;
	localparam logic [2:0] LEAF_STRING = 3'd1;
	localparam logic [2:0] LEAF_CHAR   = 3'd2;
	localparam logic [2:0] LEAF_NUMBER = 3'd3;
	localparam logic [2:0] LEAF_WORD   = 3'd4;

	localparam logic [3:0] ESC_NONE  = 4'd0;
	localparam logic [3:0] ESC_SLASH = 4'd1;
	localparam logic [3:0] ESC_HEX2  = 4'd2;
	localparam logic [3:0] ESC_OCT   = 4'd3;
	localparam logic [3:0] ESC_HEX4  = 4'd4;
	localparam logic [3:0] ESC_HEX8  = 4'd8;

	localparam logic [39:0] WORD_NULL  = 40'h006E756C6C;
	localparam logic [39:0] WORD_TRUE  = 40'h0074727565;
	localparam logic [39:0] WORD_FALSE = 40'h66616C7365;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} item_t;

	typedef struct packed {
		logic [3:0]  event_res;
		logic [31:0] value;
		logic [3:0]  error_code;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [1:0]         top;
		logic [1:0]         sub;
		logic [2:0]         leaf;
		logic [3:0]         esc;
		logic [3:0]         edig;
		logic [31:0]        acc;
		logic [2:0]         nf;
		logic [39:0]        word;
		logic [2:0]         wlen;
		logic [1:0]         lcnt;
		logic [3:0]         err;
	} st_t;

	typedef struct packed {
		st_t               st;
		logic [1:0]        n;
		res_t              r0;
		res_t              r1;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [1:0]        wr_data;
		logic              done;
	} ctx_t;

	function automatic logic is_space(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic top_dict(ctx_t x);
		return x.st.depth != '0 && x.st.top[0];
	endfunction

	function automatic ctx_t emit(ctx_t x, logic [3:0] ev, logic [31:0] v, logic [3:0] e);
		ctx_t y;
		res_t r;
		y = x;
		r.event_res = ev;
		r.value = v;
		r.error_code = e;
		r.last = 1'b0;
		if (y.n == 2'd0) y.r0 = r;
		else if (y.n == 2'd1) y.r1 = r;
		if (y.n < 2'd2) y.n = y.n + 2'd1;
		return y;
	endfunction

	function automatic ctx_t fail(ctx_t x, logic [3:0] code);
		ctx_t y;
		y = x;
		y.st.err = code;
		y = emit(y, EV_ERROR, 32'd0, code);
		return y;
	endfunction

	function automatic ctx_t push(ctx_t x, logic dict);
		ctx_t y;
		y = x;
		if (y.st.depth >= DEPTH_W'(NEST_MAX)) begin
			y = fail(y, ERR_DEPTH);
		end else begin
			if (y.st.depth != '0) begin
				y.wr_en = 1'b1;
				y.wr_addr = ADDR_W'(y.st.depth - DEPTH_W'(1));
				y.wr_data = {y.st.sub == 2'd2, y.st.top[0]};
			end
			y.st.top = {1'b0, dict};
			y.st.depth = y.st.depth + DEPTH_W'(1);
			y.st.sub = 2'd0;
			y = emit(y, dict ? EV_DIC_START : EV_ARR_START, 32'd0, ERR_NONE);
		end
		return y;
	endfunction

	function automatic ctx_t pop(ctx_t x, logic [1:0] below);
		ctx_t y;
		y = x;
		y = emit(y, top_dict(x) ? EV_DIC_END : EV_ARR_END, 32'd0, ERR_NONE);
		if (y.st.depth != '0) y.st.depth = y.st.depth - DEPTH_W'(1);
		if (y.st.depth != '0) begin
			y.st.top = below;
			y.st.sub = below[0] ? (below[1] ? 2'd3 : 2'd1) : 2'd1;
		end else begin
			y.st.sub = 2'd0;
		end
		return y;
	endfunction

	function automatic ctx_t finish(ctx_t x, logic [3:0] ev);
		ctx_t y;
		logic [3:0] e;
		y = x;
		e = ev;
		y.st.leaf = LEAF_NONE;
		if (top_dict(y)) begin
			y.st.sub = y.st.sub + 2'd1;
			if (y.st.sub == 2'd1) begin
				if (ev != EV_STRING) return fail(y, ERR_KEY);
				e = EV_KEY;
			end
		end else begin
			y.st.sub = 2'd1;
		end
		y = emit(y, e, 32'd0, ERR_NONE);
		return y;
	endfunction

	function automatic ctx_t put_char(ctx_t x, logic [31:0] cp);
		ctx_t y;
		y = x;
		if (y.st.leaf == LEAF_CHAR) begin
			if (y.st.lcnt >= 2'd1) return fail(y, ERR_CHAR_MANY);
			y.st.lcnt = y.st.lcnt + 2'd1;
		end
		y = emit(y, EV_CHAR, cp, ERR_NONE);
		return y;
	endfunction

	function automatic logic [7:0] unescape(logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c == "a") r = 8'd7;
		else if (c == "b") r = 8'd8;
		else if (c == "f") r = 8'd12;
		else if (c == "n") r = 8'd10;
		else if (c == "r") r = 8'd13;
		else if (c == "t") r = 8'd9;
		else if (c == "v") r = 8'd11;
		return r;
	endfunction

	function automatic ctx_t text_char(ctx_t x, logic [7:0] c);
		ctx_t y;
		logic [7:0] quote;
		logic [4:0] hv;
		y = x;
		y.done = 1'b1;
		quote = (y.st.leaf == LEAF_CHAR) ? 8'h27 : 8'h22;
		hv = 5'h10;
		if (is_digit(c)) hv = {1'b0, c[3:0]};
		else if (c >= "a" && c <= "f") hv = 5'(c - "a" + 8'd10);
		else if (c >= "A" && c <= "F") hv = 5'(c - "A" + 8'd10);
		if (y.st.esc == ESC_OCT) begin
			if (c >= "0" && c <= "7") begin
				y.st.acc = {y.st.acc[28:0], c[2:0]};
				y.st.edig = y.st.edig + 4'd1;
				if (y.st.edig >= 4'd3) begin
					y.st.esc = ESC_NONE;
					y = put_char(y, y.st.acc);
				end
			end else begin
				y.st.esc = ESC_NONE;
				y = put_char(y, y.st.acc);
				y.done = y.st.err != ERR_NONE;
			end
		end else if (y.st.esc >= ESC_HEX2) begin
			if (!hv[4]) begin
				y.st.acc = {y.st.acc[27:0], hv[3:0]};
				y.st.edig = y.st.edig + 4'd1;
				if (y.st.edig >= y.st.esc) begin
					y.st.esc = ESC_NONE;
					y = put_char(y, y.st.acc);
				end
			end else begin
				y.st.esc = ESC_NONE;
				y = put_char(y, y.st.acc);
				y.done = y.st.err != ERR_NONE;
			end
		end else if (y.st.esc == ESC_SLASH) begin
			y.st.acc = 32'd0;
			y.st.edig = 4'd0;
			if (c >= "0" && c <= "7") begin
				y.st.esc = ESC_OCT;
				y.st.edig = 4'd1;
				y.st.acc = {29'd0, c[2:0]};
			end else if (c == "x") y.st.esc = ESC_HEX2;
			else if (c == "u") y.st.esc = ESC_HEX4;
			else if (c == "U") y.st.esc = ESC_HEX8;
			else begin
				y.st.esc = ESC_NONE;
				y = put_char(y, {24'd0, unescape(c)});
			end
		end else if (c == 8'h5C) begin
			y.st.esc = ESC_SLASH;
		end else if (c == quote) begin
			if (y.st.leaf == LEAF_CHAR) begin
				if (y.st.lcnt == 2'd0) begin
					y.st.leaf = LEAF_NONE;
					y = fail(y, ERR_CHAR_EMPTY);
				end else begin
					y = finish(y, EV_CHARACTER);
				end
			end else begin
				y = finish(y, EV_STRING);
			end
		end else begin
			y = put_char(y, {24'd0, c});
		end
		return y;
	endfunction

	function automatic ctx_t number_char(ctx_t x, logic [7:0] c);
		ctx_t y;
		logic d;
		y = x;
		y.done = 1'b1;
		d = is_digit(c);
		if (d || (!y.st.nf[1] && (c == "+" || c == "-"))) begin
			y = emit(y, EV_CHAR, {24'd0, c}, ERR_NONE);
			y.st.nf = {d, 1'b1, y.st.nf[0]};
		end else if (!y.st.nf[0] && c == "." && y.st.nf[2]) begin
			y = emit(y, EV_CHAR, {24'd0, c}, ERR_NONE);
			y.st.nf = 3'b011;
		end else if (!y.st.nf[2]) begin
			y.st.leaf = LEAF_NONE;
			y = fail(y, ERR_NUMBER);
		end else begin
			y = finish(y, EV_NUMBER);
			y.done = y.st.err != ERR_NONE;
		end
		return y;
	endfunction

	function automatic ctx_t word_char(ctx_t x, logic [7:0] c);
		ctx_t y;
		y = x;
		y.done = 1'b1;
		if (is_alpha(c)) begin
			y = emit(y, EV_CHAR, {24'd0, c}, ERR_NONE);
			y.st.word = {y.st.word[31:0], c};
			if (y.st.wlen < 3'd6) y.st.wlen = y.st.wlen + 3'd1;
		end else begin
			y.st.leaf = LEAF_NONE;
			if (y.st.wlen == 3'd4 && y.st.word == WORD_NULL) begin
				y = finish(y, EV_NULL);
				y.done = y.st.err != ERR_NONE;
			end else if (y.st.wlen == 3'd4 && y.st.word == WORD_TRUE) begin
				y = finish(y, EV_TRUE);
				y.done = y.st.err != ERR_NONE;
			end else if (y.st.wlen == 3'd5 && y.st.word == WORD_FALSE) begin
				y = finish(y, EV_FALSE);
				y.done = y.st.err != ERR_NONE;
			end else begin
				y = fail(y, ERR_WORD);
			end
		end
		return y;
	endfunction

	function automatic ctx_t value_start(ctx_t x, logic [7:0] c);
		ctx_t y;
		y = x;
		y.done = 1'b1;
		y.st.esc = ESC_NONE;
		y.st.edig = 4'd0;
		y.st.acc = 32'd0;
		if (c == 8'h22) y.st.leaf = LEAF_STRING;
		else if (c == 8'h27) begin
			y.st.leaf = LEAF_CHAR;
			y.st.lcnt = 2'd0;
		end else if (is_digit(c) || c == "+" || c == "-") begin
			y.st.leaf = LEAF_NUMBER;
			y.st.nf = 3'd0;
			y.done = 1'b0;
		end else if (is_alpha(c)) begin
			y.st.leaf = LEAF_WORD;
			y.st.word = 40'd0;
			y.st.wlen = 3'd0;
			y.done = 1'b0;
		end else if (c == "[") y = push(y, 1'b0);
		else if (c == "{") y = push(y, 1'b1);
		else y = fail(y, ERR_BAD_CHAR);
		return y;
	endfunction

	function automatic ctx_t container_char(ctx_t x, logic [7:0] c, logic [1:0] below);
		ctx_t y;
		y = x;
		y.done = 1'b1;
		if (top_dict(y)) begin
			if (c == "}") y = pop(y, below);
			else if (c == ":") begin
				if (y.st.sub != 2'd1) y = fail(y, ERR_COLON_EXTRA);
				else y.st.sub = 2'd2;
			end else if (c == ",") begin
				if (y.st.sub != 2'd3) y = fail(y, ERR_COMMA_EXTRA);
				else y.st.sub = 2'd0;
			end else if (is_space(c)) y.done = 1'b1;
			else if (y.st.sub == 2'd1) y = fail(y, ERR_COLON_NEEDED);
			else if (y.st.sub == 2'd3) y = fail(y, ERR_COMMA_NEEDED);
			else y = value_start(y, c);
		end else begin
			if (c == "]") y = pop(y, below);
			else if (c == ",") begin
				if (y.st.sub == 2'd0) y = fail(y, ERR_COMMA_EXTRA);
				else y.st.sub = 2'd0;
			end else if (is_space(c)) y.done = 1'b1;
			else if (y.st.sub != 2'd0) y = fail(y, ERR_COMMA_NEEDED);
			else y = value_start(y, c);
		end
		return y;
	endfunction

	function automatic ctx_t dispatch(ctx_t x, logic [7:0] c, logic [1:0] below);
		ctx_t y;
		y = x;
		y.done = 1'b1;
		if (y.st.leaf == LEAF_STRING || y.st.leaf == LEAF_CHAR) y = text_char(y, c);
		else if (y.st.leaf == LEAF_NUMBER) y = number_char(y, c);
		else if (y.st.leaf == LEAF_WORD) y = word_char(y, c);
		else if (y.st.depth == '0) begin
			if (c == "[") y = push(y, 1'b0);
			else if (c == "{") y = push(y, 1'b1);
			else if (!is_space(c)) y = fail(y, ERR_NOT_START);
		end else begin
			y = container_char(y, c, below);
		end
		return y;
	endfunction

endpackage

// File: hdl/json_stream_tokenizer.sv
// latency: a result beat can leave the cycle after its input beat is taken
// throughput: one input beat per cycle while the result queue has room for two;
// results drain at one beat per cycle while res_ready is high, from a four-entry queue
// reset: arst_n clears parser state and the queue; the nesting stack is not cleared
module json_stream_tokenizer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  jst_pkg::item_t item,
	output logic           res_valid,
	input  logic           res_ready,
	output jst_pkg::res_t  res
);
	import jst_pkg::*;

	logic       take;
	logic [1:0] wr_n;
	res_t       wr0;
	res_t       wr1;

	assign take = item_valid && item_ready;

	jst_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.item  (item),
		.res_n (wr_n),
		.res0  (wr0),
		.res1  (wr1)
	);

	jst_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_n     (wr_n),
		.wr0      (wr0),
		.wr1      (wr1),
		.room     (item_ready),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

endmodule

// File: hdl/jst_core.sv
module jst_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  jst_pkg::item_t    item,
	output logic [1:0]        res_n,
	output jst_pkg::res_t     res0,
	output jst_pkg::res_t     res1
);
	import jst_pkg::*;

	st_t                st_q;
	logic [1:0]         stk_q [NEST_MAX];
	logic [1:0]         below;
	logic [1:0]         below_q;
	logic [DEPTH_W-1:0] nxt_depth;
	logic [ADDR_W-1:0]  nxt_addr;
	ctx_t               c;

	// entry under the top is read into a register ahead, using the depth that the next cycle will have
	assign nxt_depth = take ? c.st.depth : st_q.depth;
	assign nxt_addr = ADDR_W'(nxt_depth - DEPTH_W'(2));
	assign below = below_q;

	always_comb begin
		c = '0;
		c.st = st_q;
		if (st_q.err != ERR_NONE) begin
			c = emit(c, EV_ERROR, 32'd0, st_q.err);
		end else if (item.end_of_input) begin
			if (st_q.depth != '0 || st_q.leaf != LEAF_NONE) c = fail(c, ERR_END);
		end else begin
			// a number or word start or end, or a cut-short escape, hands the same byte back
			for (int p = 0; p < 4; p++) begin
				if (p == 0 || !c.done) c = dispatch(c, item.char_code, below);
			end
		end
		if (c.n == 2'd1) c.r0.last = 1'b1;
		if (c.n == 2'd2) c.r1.last = 1'b1;
	end

	assign res_n = take ? c.n : 2'd0;
	assign res0 = c.r0;
	assign res1 = c.r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (take) begin
			st_q <= c.st;
		end
	end

	always_ff @(posedge clk) begin
		if (take && c.wr_en) begin
			stk_q[c.wr_addr] <= c.wr_data;
		end
		// a push makes the old top the entry below, so forward it
		if (take && c.wr_en && c.wr_addr == nxt_addr) begin
			below_q <= c.wr_data;
		end else begin
			below_q <= stk_q[nxt_addr];
		end
	end

endmodule

// File: hdl/jst_fifo.sv
module jst_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    wr_n,
	input  jst_pkg::res_t wr0,
	input  jst_pkg::res_t wr1,
	output logic          room,
	output logic          res_valid,
	input  logic          res_ready,
	output jst_pkg::res_t res
);
	import jst_pkg::*;

	res_t       mem_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;
	logic       rd;

	assign room = cnt_q <= 3'd2;
	assign res_valid = cnt_q != 3'd0;
	assign res = mem_q[rp_q];
	assign rd = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + wr_n;
			rp_q <= rp_q + {1'b0, rd};
			cnt_q <= cnt_q + {1'b0, wr_n} - {2'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_n != 2'd0) mem_q[wp_q] <= wr0;
		if (wr_n == 2'd2) mem_q[wp_q + 2'd1] <= wr1;
	end

endmodule

// File: hdl/jst_checker.sv
module jst_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_ready,
	input jst_pkg::res_t  res
);
	import jst_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res)) else $error("result beat dropped");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.event_res <= EV_ERROR) else $error("bad event code");

	a_errcode: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.event_res == EV_ERROR |-> res.error_code != ERR_NONE)
		else $error("error without code");

	a_noerr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.event_res != EV_ERROR |-> res.error_code == ERR_NONE)
		else $error("code on non-error beat");

endmodule

bind json_stream_tokenizer jst_checker u_jst_checker (.*);

// File: sim/token_checker.sv
module token_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic           item_ready,
	input  jst_pkg::item_t item,
	input  logic           res_valid,
	input  logic           res_ready,
	input  jst_pkg::res_t  res,
	output int             errors,
	output int             pending
);
	import jst_pkg::*;

	localparam logic [7:0] QUOTE  = 8'h22;
	localparam logic [7:0] APOS   = 8'h27;
	localparam logic [7:0] BSLASH = 8'h5C;
	localparam int NF_DOT   = 0;
	localparam int NF_BODY  = 1;
	localparam int NF_DIGIT = 2;

	logic [1:0]  nest_kind [NEST_MAX];
	int          depth;
	logic [1:0]  sub;
	logic [2:0]  leaf;
	logic [3:0]  esc;
	logic [3:0]  edig;
	logic [31:0] acc;
	logic [2:0]  nf;
	logic [39:0] word;
	logic [2:0]  wlen;
	logic [1:0]  lcnt;
	logic [3:0]  err;

	res_t token_q[$];
	res_t beat_out[2];
	int   beat_n;

	assign pending = token_q.size();

	function automatic void put(logic [3:0] ev, logic [31:0] v, logic [3:0] e);
		if (beat_n < 2) begin
			beat_out[beat_n] = '{event_res: ev, value: v, error_code: e, last: 1'b0};
			beat_n++;
		end
	endfunction

	function automatic int raise_err(logic [3:0] code);
		err = code;
		put(EV_ERROR, 32'd0, code);
		return -1;
	endfunction

	function automatic logic in_dict();
		return depth != 0 && nest_kind[depth-1][0];
	endfunction

	function automatic int open_nest(logic dict);
		if (depth >= NEST_MAX) return raise_err(ERR_DEPTH);
		if (depth > 0) nest_kind[depth-1] = {sub == 2'd2, nest_kind[depth-1][0]};
		nest_kind[depth] = {1'b0, dict};
		depth++;
		sub = 2'd0;
		put(dict ? EV_DIC_START : EV_ARR_START, 32'd0, ERR_NONE);
		return 1;
	endfunction

	function automatic int close_nest();
		logic [1:0] e;
		put(in_dict() ? EV_DIC_END : EV_ARR_END, 32'd0, ERR_NONE);
		if (depth > 0) depth--;
		if (depth > 0) begin
			e = nest_kind[depth-1];
			sub = e[0] ? (e[1] ? 2'd3 : 2'd1) : 2'd1;
		end else begin
			sub = 2'd0;
		end
		return 1;
	endfunction

	function automatic int close_leaf(logic [3:0] ev);
		leaf = LEAF_NONE;
		if (in_dict()) begin
			sub = sub + 2'd1;
			if (sub == 2'd1) begin
				if (ev != EV_STRING) return raise_err(ERR_KEY);
				ev = EV_KEY;
			end
		end else begin
			sub = 2'd1;
		end
		put(ev, 32'd0, ERR_NONE);
		return 1;
	endfunction

	function automatic int text_out(logic [31:0] cp);
		if (leaf == LEAF_CHAR) begin
			if (lcnt >= 2'd1) return raise_err(ERR_CHAR_MANY);
			lcnt++;
		end
		put(EV_CHAR, cp, ERR_NONE);
		return 1;
	endfunction

	function automatic logic [7:0] c_escape(logic [7:0] c);
		case (c)
			"a": return 8'd7;
			"b": return 8'd8;
			"f": return 8'd12;
			"n": return 8'd10;
			"r": return 8'd13;
			"t": return 8'd9;
			"v": return 8'd11;
			default: return c;
		endcase
	endfunction

	function automatic int text_step(logic [7:0] c);
		logic [7:0] q;
		int hv;
		q = (leaf == LEAF_CHAR) ? APOS : QUOTE;
		if (esc == ESC_OCT) begin
			if (c >= "0" && c <= "7") begin
				acc = acc * 8 + 32'(c - 8'd48);
				edig++;
				if (edig >= 4'd3) begin
					esc = ESC_NONE;
					return text_out(acc);
				end
				return 1;
			end
			esc = ESC_NONE;
			if (text_out(acc) < 0) return -1;
			return 0;
		end
		if (esc >= ESC_HEX2) begin
			hv = -1;
			if (c >= "0" && c <= "9") hv = c - 8'd48;
			else if (c >= "a" && c <= "f") hv = c - 8'd87;
			else if (c >= "A" && c <= "F") hv = c - 8'd55;
			if (hv >= 0) begin
				acc = acc * 16 + 32'(hv);
				edig++;
				if (edig >= esc) begin
					esc = ESC_NONE;
					return text_out(acc);
				end
				return 1;
			end
			esc = ESC_NONE;
			if (text_out(acc) < 0) return -1;
			return 0;
		end
		if (esc == ESC_SLASH) begin
			acc = 32'd0;
			edig = 4'd0;
			if (c >= "0" && c <= "7") begin
				esc = ESC_OCT;
				edig = 4'd1;
				acc = 32'(c - 8'd48);
			end else if (c == "x") esc = ESC_HEX2;
			else if (c == "u") esc = ESC_HEX4;
			else if (c == "U") esc = ESC_HEX8;
			else begin
				esc = ESC_NONE;
				return text_out({24'd0, c_escape(c)});
			end
			return 1;
		end
		if (c == BSLASH) begin
			esc = ESC_SLASH;
			return 1;
		end
		if (c == q) begin
			if (leaf == LEAF_CHAR) begin
				if (lcnt == 2'd0) begin
					leaf = LEAF_NONE;
					return raise_err(ERR_CHAR_EMPTY);
				end
				return close_leaf(EV_CHARACTER);
			end
			return close_leaf(EV_STRING);
		end
		return text_out({24'd0, c});
	endfunction

	function automatic int number_step(logic [7:0] c);
		logic d;
		d = c >= "0" && c <= "9";
		if (d || (!nf[NF_BODY] && (c == "+" || c == "-"))) begin
			put(EV_CHAR, {24'd0, c}, ERR_NONE);
			nf = {d, 1'b1, nf[NF_DOT]};
			return 1;
		end
		if (!nf[NF_DOT] && c == "." && nf[NF_DIGIT]) begin
			put(EV_CHAR, {24'd0, c}, ERR_NONE);
			nf = 3'b011;
			return 1;
		end
		if (!nf[NF_DIGIT]) begin
			leaf = LEAF_NONE;
			return raise_err(ERR_NUMBER);
		end
		if (close_leaf(EV_NUMBER) < 0) return -1;
		return 0;
	endfunction

	function automatic int word_step(logic [7:0] c);
		logic [3:0] ev;
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
			put(EV_CHAR, {24'd0, c}, ERR_NONE);
			word = {word[31:0], c};
			if (wlen < 3'd6) wlen++;
			return 1;
		end
		leaf = LEAF_NONE;
		if (wlen == 3'd4 && word == WORD_NULL) ev = EV_NULL;
		else if (wlen == 3'd4 && word == WORD_TRUE) ev = EV_TRUE;
		else if (wlen == 3'd5 && word == WORD_FALSE) ev = EV_FALSE;
		else return raise_err(ERR_WORD);
		if (close_leaf(ev) < 0) return -1;
		return 0;
	endfunction

	function automatic int start_value(logic [7:0] c);
		esc = ESC_NONE;
		edig = 4'd0;
		acc = 32'd0;
		if (c == QUOTE) begin
			leaf = LEAF_STRING;
			return 1;
		end
		if (c == APOS) begin
			leaf = LEAF_CHAR;
			lcnt = 2'd0;
			return 1;
		end
		if ((c >= "0" && c <= "9") || c == "+" || c == "-") begin
			leaf = LEAF_NUMBER;
			nf = 3'd0;
			return 0;
		end
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
			leaf = LEAF_WORD;
			word = 40'd0;
			wlen = 3'd0;
			return 0;
		end
		if (c == "[") return open_nest(1'b0);
		if (c == "{") return open_nest(1'b1);
		return raise_err(ERR_BAD_CHAR);
	endfunction

	function automatic logic blank(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic int nest_step(logic [7:0] c);
		if (in_dict()) begin
			if (c == "}") return close_nest();
			if (c == ":") begin
				if (sub != 2'd1) return raise_err(ERR_COLON_EXTRA);
				sub = 2'd2;
				return 1;
			end
			if (c == ",") begin
				if (sub != 2'd3) return raise_err(ERR_COMMA_EXTRA);
				sub = 2'd0;
				return 1;
			end
			if (blank(c)) return 1;
			if (sub == 2'd1) return raise_err(ERR_COLON_NEEDED);
			if (sub == 2'd3) return raise_err(ERR_COMMA_NEEDED);
			return start_value(c);
		end
		if (c == "]") return close_nest();
		if (c == ",") begin
			if (sub == 2'd0) return raise_err(ERR_COMMA_EXTRA);
			sub = 2'd0;
			return 1;
		end
		if (blank(c)) return 1;
		if (sub != 2'd0) return raise_err(ERR_COMMA_NEEDED);
		return start_value(c);
	endfunction

	function automatic int route_byte(logic [7:0] c);
		case (leaf)
			LEAF_STRING, LEAF_CHAR: return text_step(c);
			LEAF_NUMBER: return number_step(c);
			LEAF_WORD: return word_step(c);
			default: ;
		endcase
		if (depth == 0) begin
			if (c == "[") return open_nest(1'b0);
			if (c == "{") return open_nest(1'b1);
			if (blank(c)) return 1;
			return raise_err(ERR_NOT_START);
		end
		return nest_step(c);
	endfunction

	function automatic void predict_tokens(item_t it);
		beat_n = 0;
		if (err != ERR_NONE) begin
			put(EV_ERROR, 32'd0, err);
		end else if (it.end_of_input) begin
			if (depth != 0 || leaf != LEAF_NONE) void'(raise_err(ERR_END));
		end else begin
			for (int p = 0; p < 4; p++)
				if (route_byte(it.char_code) != 0) break;
		end
		if (beat_n > 0) beat_out[beat_n-1].last = 1'b1;
		for (int i = 0; i < beat_n; i++) token_q.push_back(beat_out[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			depth = 0;
			sub = 2'd0;
			leaf = LEAF_NONE;
			esc = ESC_NONE;
			edig = 4'd0;
			acc = 32'd0;
			nf = 3'd0;
			word = 40'd0;
			wlen = 3'd0;
			lcnt = 2'd0;
			err = ERR_NONE;
			token_q.delete();
			errors = 0;
		end else begin
			if (item_valid && item_ready) predict_tokens(item);
			if (res_valid && res_ready) begin
				if (token_q.size() == 0) begin
					$error("unexpected result beat: event_res %0d value %0h", res.event_res,
						res.value);
					errors++;
				end else begin
					want = token_q.pop_front();
					if (res.event_res !== want.event_res) begin
						$error("event_res: expected %0d, got %0d", want.event_res, res.event_res);
						errors++;
					end
					if (res.value !== want.value) begin
						$error("value: expected %0h, got %0h", want.value, res.value);
						errors++;
					end
					if (res.error_code !== want.error_code) begin
						$error("error_code: expected %0d, got %0d", want.error_code,
							res.error_code);
						errors++;
					end
					if (res.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, res.last);
						errors++;
					end
				end
			end
		end
	end

endmodule

// File: sim/testbench.sv
module testbench;
	import jst_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam logic [7:0] QUOTE  = 8'h22;
	localparam logic [7:0] APOS   = 8'h27;
	localparam logic [7:0] BSLASH = 8'h5C;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_ready;
	item_t item = '0;
	logic  res_valid;
	logic  res_ready = 1'b0;
	res_t  res;
	int    errors;
	int    pending;

	int         sent = 0;
	int         stall = 0;
	logic       steady = 1'b0;
	logic [7:0] text [$];

	always #1 clk = ~clk;

	json_stream_tokenizer dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	token_checker chk (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.errors(errors), .pending(pending)
	);

	always @(negedge clk) begin
		res_ready <= steady || $urandom_range(99) >= 12;
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (res_valid && res_ready)) stall <= 0;
		else stall <= stall + 1;
		if (stall >= STALL_LIMIT) begin
			$display("[json_stream_tokenizer] ERROR");
			$finish;
		end
	end

	// one beat, called at a falling edge, returns at a falling edge
	task automatic send_beat(logic [7:0] c, logic eoi);
		steady = sent >= 500 && sent < 800;
		while (!steady && $urandom_range(99) < 12) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		item.char_code = c;
		item.end_of_input = eoi;
		// ready only moves at a rising edge, so it is stable here
		while (!item_ready) @(negedge clk);
		@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic flush_text();
		foreach (text[i]) send_beat(text[i], 1'b0);
		text.delete();
	endtask

	function automatic void add(string s);
		for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
	endfunction

	function automatic void add_blank();
		logic [7:0] sp [6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
		repeat ($urandom_range(0, 2)) text.push_back(sp[$urandom_range(0, 5)]);
	endfunction

	function automatic void add_hex(int n);
		string hx = "0123456789abcdefABCDEF";
		repeat (n) text.push_back(hx[$urandom_range(0, 21)]);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == QUOTE || b == APOS || b == BSLASH);
		return b;
	endfunction

	function automatic void add_string();
		text.push_back(QUOTE);
		repeat ($urandom_range(0, 6)) begin
			if ($urandom_range(0, 9) < 7) begin
				text.push_back(plain_byte());
			end else begin
				text.push_back(BSLASH);
				case ($urandom_range(0, 4))
					0: text.push_back(8'($urandom_range(0, 255)));
					1: repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(48, 55)));
					2: begin text.push_back("x"); add_hex($urandom_range(0, 2)); end
					3: begin text.push_back("u"); add_hex($urandom_range(0, 4)); end
					default: begin text.push_back("U"); add_hex($urandom_range(0, 8)); end
				endcase
			end
		end
		text.push_back(QUOTE);
	endfunction

	function automatic void add_charlit();
		string ce = "abfnrtvq";
		text.push_back(APOS);
		case ($urandom_range(0, 4))
			0: begin text.push_back(BSLASH); text.push_back(ce[$urandom_range(0, 7)]); end
			1: begin text.push_back(BSLASH); text.push_back("x"); add_hex(2); end
			2: begin
				text.push_back(BSLASH);
				repeat (3) text.push_back(8'($urandom_range(48, 55)));
			end
			default: text.push_back(plain_byte());
		endcase
		text.push_back(APOS);
	endfunction

	function automatic void add_number();
		case ($urandom_range(0, 3))
			0: text.push_back("-");
			1: text.push_back("+");
			default: ;
		endcase
		repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(48, 57)));
		if ($urandom_range(0, 2) == 0) begin
			text.push_back(".");
			repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(48, 57)));
		end
	endfunction

	function automatic void add_value(int lvl);
		case ($urandom_range(0, 9))
			0, 1, 2: add_string();
			3: add_charlit();
			4, 5: add_number();
			6: case ($urandom_range(0, 2))
				0: add("null");
				1: add("true");
				default: add("false");
			endcase
			default: if (lvl < 4) add_nest(lvl + 1); else add_number();
		endcase
	endfunction

	function automatic void add_nest(int lvl);
		int n;
		logic dict;
		n = $urandom_range(0, 4);
		dict = 1'($urandom_range(0, 1));
		text.push_back(dict ? "{" : "[");
		for (int i = 0; i < n; i++) begin
			add_blank();
			if (dict) begin
				// a container may stand in key position
				if (lvl < 4 && $urandom_range(0, 15) == 0) add_nest(lvl + 1);
				else add_string();
				add_blank();
				text.push_back(":");
				add_blank();
			end
			add_value(lvl);
			add_blank();
			if (i < n - 1 || $urandom_range(0, 9) == 0) text.push_back(",");
		end
		add_blank();
		text.push_back(dict ? "}" : "]");
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: every event but EV_ERROR, all escape kinds, lenient closes, container key
		add("{\"k\\n\\x41\\101\\8\\u00e9\\U0001F600\\q\\x\":[1,-2.5,+3,null,true,false,");
		add("'a','\\t',{}],[]:\"v\",\"e\":}");
		add(" [1,]{}\t[[[");
		// high bytes as plain string content
		text.push_back(QUOTE);
		text.push_back(8'hFF);
		text.push_back(8'h80);
		text.push_back(QUOTE);
		add("]]]");
		flush_text();
		send_beat(8'h00, 1'b1);
		// deepest legal nesting
		repeat (NEST_MAX) text.push_back("[");
		repeat (NEST_MAX) text.push_back("]");
		flush_text();

		while (sent < 1600) begin
			add_blank();
			add_nest(0);
			add_blank();
			flush_text();
			if ($urandom_range(0, 3) == 0) send_beat(8'($urandom_range(0, 255)), 1'b1);
		end

		// one broken tail at the end, since errors stick until reset
		case ($urandom_range(0, 12))
			0: add("x");
			1: add("[,");
			2: add("[1 2");
			3: add("{:");
			4: add("{\"a\" 1");
			5: add("[#");
			6: add("{1}");
			7: add("[-]");
			8: add("[nul]");
			9: begin text.push_back("["); text.push_back(APOS); text.push_back(APOS); end
			10: begin
				text.push_back("[");
				text.push_back(APOS);
				add("ab");
				text.push_back(APOS);
			end
			11: add("[1");
			default: repeat (NEST_MAX + 1) text.push_back("[");
		endcase
		flush_text();
		send_beat(8'h00, 1'b1);
		repeat (6) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		item_valid = 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("[json_stream_tokenizer] OK");
		end else begin
			$display("[json_stream_tokenizer] ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/jst_pkg.sv
hdl/jst_core.sv
hdl/jst_fifo.sv
hdl/json_stream_tokenizer.sv
hdl/jst_checker.sv
sim/token_checker.sv
sim/testbench.sv
